// ----- sv/lndp_pkg.sv -----
`timescale 1ns / 1ps

package lndp_pkg;

	// program counter width and entry points
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] ST_IDLE = 4'd0;
	localparam logic [PC_W-1:0] ST_DISP = 4'd1;
	localparam logic [PC_W-1:0] ST_SIGN = 4'd2;
	localparam logic [PC_W-1:0] ST_MHI  = 4'd3;
	localparam logic [PC_W-1:0] ST_MLO  = 4'd4;
	localparam logic [PC_W-1:0] ST_SUB  = 4'd5;
	localparam logic [PC_W-1:0] ST_DIG  = 4'd6;
	localparam logic [PC_W-1:0] ST_DHI  = 4'd7;
	localparam logic [PC_W-1:0] ST_DLO  = 4'd8;
	localparam logic [PC_W-1:0] ST_NEXT = 4'd9;
	localparam logic [PC_W-1:0] ST_RHI  = 4'd10;
	localparam logic [PC_W-1:0] ST_RLO  = 4'd11;

	// characters and decimal weights
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [3:0] TOP_IDX     = 4'd9;

	typedef struct packed {
		logic               cmd;
		logic [7:0]         byte_value;
		logic               is_data;
		logic signed [31:0] number;
	} item_t;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_HI,
		OP_LO,
		OP_SUB,
		OP_DIGIT,
		OP_NEXT
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NOIN,
		C_RAW,
		C_NEG,
		C_BUSY,
		C_GE,
		C_SKIP,
		C_UNIT
	} cond_t;

	typedef enum logic [1:0] {
		LAST_NO,
		LAST_YES,
		LAST_UNIT
	} last_t;

	// one control word of the program
	typedef struct packed {
		op_t             op;
		last_t           last_sel;
		cond_t           cond;
		logic [PC_W-1:0] tgt;
		logic [PC_W-1:0] nxt;
	} uword_t;

	// control from sequencer to datapath
	typedef struct packed {
		op_t   op;
		last_t last_sel;
		logic  idle;
	} ctrl_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic in_acc;
		logic raw;
		logic neg;
		logic busy;
		logic ge;
		logic skip;
		logic unit;
	} status_t;

	// decimal weight for digit position idx
	function automatic logic [29:0] pow10(input logic [3:0] idx);
		logic [29:0] p;
		case (idx)
			4'd0: p = 30'd1;
			4'd1: p = 30'd10;
			4'd2: p = 30'd100;
			4'd3: p = 30'd1000;
			4'd4: p = 30'd10000;
			4'd5: p = 30'd100000;
			4'd6: p = 30'd1000000;
			4'd7: p = 30'd10000000;
			4'd8: p = 30'd100000000;
			4'd9: p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

	// microprogram
	function automatic uword_t rom_word(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			ST_IDLE: w = '{OP_LOAD,  LAST_NO,   C_NOIN,   ST_IDLE, ST_DISP};
			ST_DISP: w = '{OP_NONE,  LAST_NO,   C_RAW,    ST_RHI,  ST_SIGN};
			ST_SIGN: w = '{OP_NONE,  LAST_NO,   C_NEG,    ST_MHI,  ST_SUB};
			ST_MHI:  w = '{OP_HI,    LAST_NO,   C_BUSY,   ST_MHI,  ST_MLO};
			ST_MLO:  w = '{OP_LO,    LAST_NO,   C_BUSY,   ST_MLO,  ST_SUB};
			ST_SUB:  w = '{OP_SUB,   LAST_NO,   C_GE,     ST_SUB,  ST_DIG};
			ST_DIG:  w = '{OP_DIGIT, LAST_NO,   C_SKIP,   ST_NEXT, ST_DHI};
			ST_DHI:  w = '{OP_HI,    LAST_NO,   C_BUSY,   ST_DHI,  ST_DLO};
			ST_DLO:  w = '{OP_LO,    LAST_UNIT, C_BUSY,   ST_DLO,  ST_NEXT};
			ST_NEXT: w = '{OP_NEXT,  LAST_NO,   C_UNIT,   ST_IDLE, ST_SUB};
			ST_RHI:  w = '{OP_HI,    LAST_NO,   C_BUSY,   ST_RHI,  ST_RLO};
			ST_RLO:  w = '{OP_LO,    LAST_YES,  C_BUSY,   ST_RLO,  ST_IDLE};
			default: w = '{OP_NONE,  LAST_NO,   C_ALWAYS, ST_IDLE, ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- sv/lndp_seq.sv -----
`timescale 1ns / 1ps

module lndp_seq import lndp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	output ctrl_t   ctrl
);

	logic [PC_W-1:0] pc_q;
	uword_t          w;
	logic            take;

	// fetch the control word of the current step
	assign w = rom_word(pc_q);

	always_comb begin
		case (w.cond)
			C_ALWAYS: take = 1'b1;
			C_NOIN:   take = ~st.in_acc;
			C_RAW:    take = st.raw;
			C_NEG:    take = st.neg;
			C_BUSY:   take = st.busy;
			C_GE:     take = st.ge;
			C_SKIP:   take = st.skip;
			C_UNIT:   take = st.unit;
			default:  take = 1'b1;
		endcase
	end

	assign ctrl.op       = w.op;
	assign ctrl.last_sel = w.last_sel;
	assign ctrl.idle     = (pc_q == ST_IDLE);

	// step counter with conditional jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= take ? w.tgt : w.nxt;
		end
	end

endmodule

// ----- sv/lndp_dp.sv -----
`timescale 1ns / 1ps

module lndp_dp import lndp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ctrl_t   ctrl,
	input  logic    item_valid,
	input  item_t   item,
	input  logic    result_stall,
	output logic    result_valid,
	output result_t result,
	output status_t st
);

	logic [31:0] mag_q;
	logic [3:0]  pidx_q;
	logic [3:0]  digit_q;
	logic        started_q;
	logic        raw_q;
	logic        neg_q;
	logic        rs_q;
	logic [7:0]  char_q;
	logic        out_valid_q;
	result_t     out_q;

	logic [31:0] pow;
	logic        ge;
	logic        busy;
	logic        in_acc;
	logic        last_bit;
	logic [31:0] abs_num;

	assign pow     = {2'b00, pow10(pidx_q)};
	assign ge      = (mag_q >= pow);
	assign busy    = out_valid_q & result_stall;
	assign in_acc  = item_valid & ctrl.idle;
	assign abs_num = item.number[31] ? (~item.number + 32'd1) : item.number;

	assign st.in_acc = in_acc;
	assign st.raw    = raw_q;
	assign st.neg    = neg_q;
	assign st.busy   = busy;
	assign st.ge     = ge;
	assign st.skip   = (digit_q == 4'd0) & ~started_q & (pidx_q != 4'd0);
	assign st.unit   = (pidx_q == 4'd0);

	always_comb begin
		case (ctrl.last_sel)
			LAST_NO:   last_bit = 1'b0;
			LAST_YES:  last_bit = 1'b1;
			LAST_UNIT: last_bit = (pidx_q == 4'd0);
			default:   last_bit = 1'b0;
		endcase
	end

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q     <= 1'b0;
			neg_q     <= 1'b0;
			rs_q      <= 1'b0;
			char_q    <= 8'd0;
			mag_q     <= 32'd0;
			pidx_q    <= 4'd0;
			digit_q   <= 4'd0;
			started_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_LOAD: begin
					if (in_acc) begin
						raw_q     <= ~item.cmd;
						neg_q     <= item.number[31];
						rs_q      <= item.cmd | item.is_data;
						char_q    <= item.cmd ? ASCII_MINUS : item.byte_value;
						mag_q     <= abs_num;
						pidx_q    <= TOP_IDX;
						digit_q   <= 4'd0;
						started_q <= 1'b0;
					end
				end
				OP_SUB: begin
					if (ge) begin
						mag_q   <= mag_q - pow;
						digit_q <= digit_q + 4'd1;
					end
				end
				OP_DIGIT: begin
					char_q    <= ASCII_ZERO + {4'd0, digit_q};
					started_q <= started_q | (digit_q != 4'd0) | (pidx_q == 4'd0);
				end
				OP_NEXT: begin
					digit_q <= 4'd0;
					if (pidx_q != 4'd0) begin
						pidx_q <= pidx_q - 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register, loaded only when the previous beat is gone or is taken in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.op == OP_HI || ctrl.op == OP_LO) && !busy) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (ctrl.op == OP_HI && !busy) begin
			out_q.nibble     <= char_q[7:4];
			out_q.reg_select <= rs_q;
			out_q.last       <= 1'b0;
		end else if (ctrl.op == OP_LO && !busy) begin
			out_q.nibble     <= char_q[3:0];
			out_q.reg_select <= rs_q;
			out_q.last       <= last_bit;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// digit extraction has run to completion before a digit is formed
	a_digit_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_DIGIT |-> mag_q < pow)
		else $error("digit formed before extraction finished");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_DIGIT |-> digit_q <= 4'd9)
		else $error("decimal digit out of range");

	a_low_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_LO && !busy) |=> out_valid_q && out_q.nibble == $past(char_q[3:0]))
		else $error("low nibble not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_HI && busy) |=> $stable(out_q))
		else $error("waiting beat overwritten");

endmodule

// ----- sv/lcd_nibble_writer_decimal_print.sv -----
`timescale 1ns / 1ps

// Character LCD 4-bit writer with decimal print.
// Item channel (item_valid / item_stall / item): an item either sends one
// raw byte with its register-select bit (cmd 0) or prints a signed 32-bit
// number in decimal (cmd 1). An item is taken only while the sequencer is
// at its idle step; item_stall is high for the whole time an item is worked.
// Result channel (result_valid / result_stall / result): one beat per enable
// pulse, high nibble first, last set on the final nibble of the item.
// A raw byte passes the accept, the raw/number check and its high and low
// nibble steps before the next item is taken. A number passes the accept,
// the check, the sign check, the nibble steps of a minus sign if negative,
// and per decimal position a subtraction of the weight while it fits, the
// failing compare, forming the digit, its nibble steps if it is printed
// and the step to the next weight. The first beat comes after the check
// for a raw byte or the sign check if negative, else after the leading digit.
// A held result_stall stops the sequencer at the next nibble step; nothing
// is lost, and a new item may be taken while the last beat still waits.
// Reset clears the step counter and the output valid; the block is idle
// and ready for an item right after reset.

module lcd_nibble_writer_decimal_print import lndp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	ctrl_t   ctrl;
	status_t st;

	lndp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	lndp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.item_valid   (item_valid),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.st           (st)
	);

	assign item_stall = ~ctrl.idle;

endmodule

// ----- tb/sv/tb_lcd_nibble_writer_decimal_print.sv -----
`timescale 1ns / 1ps

module tb_lcd_nibble_writer_decimal_print;
	import lndp_pkg::*;

	// request kinds and register-select levels
	localparam logic CMD_RAW   = 1'b0;
	localparam logic CMD_PRINT = 1'b1;
	localparam logic RS_CMD    = 1'b0;
	localparam logic RS_DATA   = 1'b1;

	localparam int RANDOM_ITEMS = 189;
	localparam int MAX_REPORTS  = 30;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	item_t   pending_items[$];
	result_t expected_writes[$];
	logic    item_taken = 1'b0;
	int      items_sent = 0;
	int      items_accepted = 0;
	int      total_items = 0;
	int      raw_items = 0;
	int      print_items = 0;
	int      writes_checked = 0;
	int      mismatches = 0;

	lcd_nibble_writer_decimal_print dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// expected nibble writes for one request: chars first, then two nibbles each
	task automatic predict_lcd_writes(input item_t req);
		logic [7:0]  chars[$];
		logic        rs;
		logic [31:0] magnitude;
		logic [31:0] weight;
		logic [3:0]  digit;
		logic        started;
		started = 1'b0;
		if (req.cmd == CMD_RAW) begin
			chars.push_back(req.byte_value);
			rs = req.is_data;
		end else begin
			rs = RS_DATA;
			magnitude = req.number;
			if (req.number[31]) begin
				chars.push_back(ASCII_MINUS);
				magnitude = 32'd0 - req.number;
			end
			weight = 32'd1000000000;
			for (int k = 0; k < 10; k++) begin
				digit = 4'(magnitude / weight);
				magnitude = magnitude % weight;
				// leading zeros dropped, units digit always shown
				if (digit != 4'd0 || started || weight == 32'd1) begin
					started = 1'b1;
					chars.push_back(ASCII_ZERO + {4'd0, digit});
				end
				weight = weight / 32'd10;
			end
		end
		foreach (chars[i]) begin
			expected_writes.push_back('{chars[i][7:4], rs, 1'b0});
			expected_writes.push_back('{chars[i][3:0], rs, i == chars.size() - 1});
		end
	endtask

	task automatic add_lcd_request(input logic cmd, input logic [7:0] byte_value,
			input logic is_data, input logic [31:0] number);
		item_t req;
		req.cmd        = cmd;
		req.byte_value = byte_value;
		req.is_data    = is_data;
		req.number     = number;
		pending_items.push_back(req);
	endtask

	// sender: new beat only when the line is free or the last beat was taken
	always @(negedge clk) begin
		int send_idle;
		int recv_idle;
		if (items_sent < 95) begin
			send_idle = 21;
			recv_idle = 77;
		end else if (items_sent < 165) begin
			send_idle = 77;
			recv_idle = 21;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		if (arst_n && (!item_valid || item_taken)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
				item       <= pending_items.pop_front();
				item_valid <= 1'b1;
				items_sent <= items_sent + 1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_stall <= arst_n && ($urandom_range(99) < recv_idle);
	end

	// monitor: check result beats, then predict for accepted requests
	always @(posedge clk) begin
		result_t want;
		item_taken = arst_n && item_valid && !item_stall;
		if (arst_n && result_valid && !result_stall) begin
			writes_checked++;
			if (expected_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected beat nibble=%h rs=%b last=%b",
						$time, result.nibble, result.reg_select, result.last);
			end else begin
				want = expected_writes.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected %h/%b/%b, got %h/%b/%b",
							$time, want.nibble, want.reg_select, want.last,
							result.nibble, result.reg_select, result.last);
				end
			end
		end
		if (item_taken) begin
			predict_lcd_writes(item);
			items_accepted++;
			if (item.cmd == CMD_RAW)
				raw_items++;
			else
				print_items++;
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned digits;
		int unsigned lo;
		int unsigned hi;
		int unsigned mag;
		int unsigned w;
		int unsigned pick;
		logic [31:0] value;

		// corner requests: byte extremes, both rs levels, number edges
		add_lcd_request(CMD_RAW, 8'h00, RS_CMD, $urandom());
		add_lcd_request(CMD_RAW, 8'hFF, RS_DATA, $urandom());
		add_lcd_request(CMD_RAW, 8'hA5, RS_CMD, 32'hFFFFFFFF);
		add_lcd_request(CMD_RAW, 8'h5A, RS_DATA, 32'h00000000);
		add_lcd_request(CMD_PRINT, 8'hFF, RS_DATA, 32'd0);
		add_lcd_request(CMD_PRINT, 8'h00, RS_CMD, 32'd1);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), -32'sd1);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd9);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd10);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd100);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'h7FFFFFFF);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'h80000000);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'h80000001);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd1000000000);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), -32'sd1000000000);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd999999999);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd1000000001);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd2000000000);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd1234567890);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), -32'sd987654321);
		add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), -32'sd10);

		// random mix, numbers spread over every digit count
		repeat (RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				add_lcd_request(CMD_RAW, 8'($urandom()), 1'($urandom()), $urandom());
			end else if (pick < 36) begin
				add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), $urandom());
			end else if (pick < 39) begin
				add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'h80000000);
			end else if (pick < 42) begin
				add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), 32'd0);
			end else begin
				digits = $urandom_range(10, 1);
				lo = 1;
				repeat (digits - 1) lo = lo * 10;
				hi = (digits == 10) ? 32'd2147483647 : lo * 10 - 1;
				mag = $urandom_range(hi, lo);
				// sometimes zero out the low digits for inner zeros
				if ($urandom_range(3) == 0) begin
					w = 1;
					repeat ($urandom_range(digits - 1)) w = w * 10;
					mag = mag - mag % w;
				end
				value = $urandom_range(1) ? 32'd0 - mag : mag;
				add_lcd_request(CMD_PRINT, 8'($urandom()), 1'($urandom()), value);
			end
		end
		total_items = pending_items.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_accepted < total_items || expected_writes.size() != 0)
			@(posedge clk);
		// catch any stray beat after the final one
		repeat (200) @(posedge clk);

		$display("ran %0d raw byte writes and %0d decimal prints under mixed stalls",
			raw_items, print_items);
		$display("checked %0d nibble beats, %0d mismatches", writes_checked, mismatches);
		if (mismatches == 0 && expected_writes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hard stop in case the block hangs
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
